[sv/mpe_pkg.sv]
// ----------------------------------------------------------------------------
// mpe_pkg: shared types and constants for the M_PDU packet extractor
// Register indexes, field widths, the result entry type and output queue size.
// ----------------------------------------------------------------------------
package mpe_pkg;

  localparam int ZONE_W     = 11;
  localparam int PTRPOS_W   = 10;
  localparam int CFG_DATA_W = 11;
  localparam int POS_W      = 12;
  localparam int FHP_W      = 11;
  localparam int BYTE_W     = 8;

  // Configuration register indexes.
  localparam logic CFG_ZONE_LENGTH      = 1'b0;
  localparam logic CFG_POINTER_POSITION = 1'b1;

  localparam logic [ZONE_W-1:0]   ZONE_LENGTH_RST      = 11'd882;
  localparam logic [PTRPOS_W-1:0] POINTER_POSITION_RST = 10'd8;

  // A first header pointer of all ones marks a frame of continuation data only.
  localparam logic [FHP_W-1:0] FHP_CONT_ONLY = 11'b111_1111_1111;
  localparam logic [POS_W-1:0] POS_MAX       = 12'd4095;

  // Output queue: four entries, so two free slots always exist on accept.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] packet_byte;
    logic              packet_last;
    logic              empty_end;
  } res_t;

endpackage

[sv/mpe_if.sv]
// ----------------------------------------------------------------------------
// mpe_if: valid/ready channels of the M_PDU packet extractor
// One interface for frame bytes in, one for packet bytes out.
// ----------------------------------------------------------------------------
interface mpe_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_first;

  modport source (output valid, output frame_byte, output frame_first, input ready);
  modport sink   (input valid, input frame_byte, input frame_first, output ready);
endinterface

interface mpe_packet_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_last;
  logic       empty_end;

  modport source (output valid, output packet_byte, output packet_last,
                  output empty_end, input ready);
  modport sink   (input valid, input packet_byte, input packet_last,
                  input empty_end, output ready);
endinterface

[sv/mpdu_packet_extractor.sv]
// ----------------------------------------------------------------------------
// mpdu_packet_extractor: first header pointer packet demultiplexer
// Splits fixed-size transfer frames into packets using the 11-bit pointer.
// ----------------------------------------------------------------------------
//
//   Channel      Direction  Handshake     Payload
//   in_frame     in         valid/ready   frame_byte[7:0], frame_first
//   out_packet   out        valid/ready   packet_byte[7:0], packet_last, empty_end
//   cfg_*        in         write enable  cfg_index[0], cfg_data[10:0]
//
// One frame byte is accepted per cycle while in_frame.ready is high. Each byte
// is decided in the cycle it is accepted, and its zero, one or two result
// items are written into a four-entry output queue that drains one item per
// cycle while out_packet.ready is high. in_frame.ready is high while the
// queue has room for two items, so it drops once three items are waiting.
// Reset (synchronous, active low) clears the frame tracking state, the held
// byte and the queue, and loads the configuration defaults (882 and 8).
//
// Each frame byte walks a byte counter. The two bytes at pointer_position
// carry the first header pointer. A frame whose pointer exceeds zone_length
// and is not the continuation code is dropped. Packet bytes pass through a
// one-byte hold-back register so the byte that ends a packet carries
// packet_last; when no byte is held the end is signalled by an empty marker.
module mpdu_packet_extractor
  import mpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mpe_frame_if.sink             in_frame,
  mpe_packet_if.source          out_packet,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [ZONE_W-1:0]   zone_length_r;
  logic [PTRPOS_W-1:0] pointer_position_r;

  // Frame tracking state.
  logic [POS_W-1:0]  byte_position_r, byte_position_nxt;
  logic [FHP_W-1:0]  pointer_value_r, pointer_value_nxt;
  logic              frame_accepted_r, frame_accepted_nxt;
  logic              packet_open_r, packet_open_nxt;
  logic [BYTE_W-1:0] held_byte_r, held_byte_nxt;
  logic              held_valid_r, held_valid_nxt;

  // Output queue.
  res_t           queue_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  logic in_acc, out_acc;

  assign in_frame.ready = (count_r <= QCW'(QDEPTH - 2));
  assign in_acc         = in_frame.valid && in_frame.ready;
  assign out_acc        = out_packet.valid && out_packet.ready;

  // Per-byte decision.
  logic [POS_W-1:0] pos, pp_ext, zone_idx1;
  logic [FHP_W-1:0] fhp_low;
  logic             fa_cur;
  logic             at_ptr_hi, at_ptr_lo, in_zone;
  logic             do_push, do_end;
  logic             hv_after_push;
  logic [BYTE_W-1:0] hb_after_push;
  res_t             res_a, res_b;
  logic             emit_a, emit_b;

  always_comb begin
    pos       = in_frame.frame_first ? '0 : byte_position_r;
    pp_ext    = POS_W'(pointer_position_r);
    fa_cur    = in_frame.frame_first ? 1'b0 : frame_accepted_r;
    at_ptr_hi = (pos == pp_ext);
    at_ptr_lo = (pos == pp_ext + POS_W'(1));
    in_zone   = (pos >= pp_ext + POS_W'(2));
    // Zone index plus one: the pointer counts zone bytes from zero.
    zone_idx1 = pos - pp_ext - POS_W'(1);
    fhp_low   = {pointer_value_r[FHP_W-1:BYTE_W], in_frame.frame_byte};

    pointer_value_nxt  = pointer_value_r;
    frame_accepted_nxt = fa_cur;
    packet_open_nxt    = packet_open_r;
    do_push            = 1'b0;
    do_end             = 1'b0;

    priority if (at_ptr_hi) begin
      pointer_value_nxt  = {in_frame.frame_byte[2:0], {BYTE_W{1'b0}}};
      frame_accepted_nxt = 1'b0;
    end else if (at_ptr_lo) begin
      pointer_value_nxt  = fhp_low;
      frame_accepted_nxt = (fhp_low <= zone_length_r) || (fhp_low == FHP_CONT_ONLY);
      if (frame_accepted_nxt && (fhp_low == '0)) begin
        do_end          = packet_open_r;
        packet_open_nxt = 1'b1;
      end
    end else if (in_zone && fa_cur && (zone_idx1 <= POS_W'(zone_length_r))) begin
      // The byte just before the pointer closes the open packet.
      if ((pointer_value_r != FHP_CONT_ONLY) &&
          (zone_idx1 == POS_W'(pointer_value_r))) begin
        do_push         = packet_open_r;
        do_end          = packet_open_r;
        packet_open_nxt = 1'b1;
      end else begin
        do_push = packet_open_r;
      end
    end else begin
      // Bytes ahead of the pointer, past the zone, or in a dropped frame.
    end

    hv_after_push = held_valid_r | do_push;
    hb_after_push = do_push ? in_frame.frame_byte : held_byte_r;
    held_byte_nxt = hb_after_push;
    held_valid_nxt = do_end ? 1'b0 : hv_after_push;

    // A push releases the previously held byte; an end flushes the holder.
    emit_a = do_push && held_valid_r;
    res_a  = '{packet_byte: held_byte_r, packet_last: 1'b0, empty_end: 1'b0};
    emit_b = do_end;
    res_b  = hv_after_push ?
             '{packet_byte: hb_after_push, packet_last: 1'b1, empty_end: 1'b0} :
             '{packet_byte: '0, packet_last: 1'b1, empty_end: 1'b1};

    byte_position_nxt = (pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX;
  end

  // Queue write ordering: the released held byte goes ahead of the end item.
  res_t           wr0, wr1;
  logic [1:0]     n_wr;
  always_comb begin
    wr0  = emit_a ? res_a : res_b;
    wr1  = res_b;
    n_wr = in_acc ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_length_r      <= ZONE_LENGTH_RST;
      pointer_position_r <= POINTER_POSITION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZONE_LENGTH:      zone_length_r      <= cfg_data[ZONE_W-1:0];
        CFG_POINTER_POSITION: pointer_position_r <= cfg_data[PTRPOS_W-1:0];
        default:              ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r  <= '0;
      pointer_value_r  <= '0;
      frame_accepted_r <= 1'b0;
      packet_open_r    <= 1'b0;
      held_byte_r      <= '0;
      held_valid_r     <= 1'b0;
    end else if (in_acc) begin
      byte_position_r  <= byte_position_nxt;
      pointer_value_r  <= pointer_value_nxt;
      frame_accepted_r <= frame_accepted_nxt;
      packet_open_r    <= packet_open_nxt;
      held_byte_r      <= held_byte_nxt;
      held_valid_r     <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(n_wr);
      rd_ptr_r <= rd_ptr_r + QAW'(out_acc);
      count_r  <= count_r + QCW'(n_wr) - QCW'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      queue_r[wr_ptr_r] <= wr0;
    end
    if (n_wr == 2'd2) begin
      queue_r[wr_ptr_r + QAW'(1)] <= wr1;
    end
  end

  assign out_packet.valid       = (count_r != '0);
  assign out_packet.packet_byte = queue_r[rd_ptr_r].packet_byte;
  assign out_packet.packet_last = queue_r[rd_ptr_r].packet_last;
  assign out_packet.empty_end   = queue_r[rd_ptr_r].empty_end;

endmodule

[sv/mpe_checker.sv]
// ----------------------------------------------------------------------------
// mpe_checker: port-level checks for the M_PDU packet extractor
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module mpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] packet_byte,
  input logic       packet_last,
  input logic       empty_end
);

  // A stalled result item holds its place and contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(packet_byte) &&
                                $stable(packet_last) && $stable(empty_end))
    else $error("stalled result item changed");

  // An empty marker always closes a packet and carries no byte.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_end |-> packet_last && (packet_byte == 8'd0))
    else $error("empty marker without packet_last or with a byte");

  // Results only appear after a frame byte was taken.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result item appeared without an accepted frame byte");

  // The output queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result item pending right after reset");

endmodule

bind mpdu_packet_extractor mpe_checker u_mpe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_frame.valid),
  .in_ready    (in_frame.ready),
  .out_valid   (out_packet.valid),
  .out_ready   (out_packet.ready),
  .packet_byte (out_packet.packet_byte),
  .packet_last (out_packet.packet_last),
  .empty_end   (out_packet.empty_end)
);

[test/mpe_test_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_test_pkg: packet split scoreboard for the M_PDU packet extractor
// Predicts the packet items that each accepted frame byte causes and checks
// the items that leave the block against them, oldest first.
// ----------------------------------------------------------------------------
package mpe_test_pkg;

  import mpe_pkg::*;

  class mpdu_split_scoreboard;

    // Configuration as last written.
    logic [ZONE_W-1:0]   zone_len;
    logic [PTRPOS_W-1:0] ptr_pos;

    // Frame tracking state.
    logic [POS_W-1:0]  pos_cnt;
    logic [FHP_W-1:0]  fhp_val;
    bit                frame_ok;
    bit                pkt_open;
    logic [BYTE_W-1:0] held;
    bit                held_ok;

    res_t awaited_packet_items[$];
    int   mismatches;

    function new();
      zone_len   = ZONE_LENGTH_RST;
      ptr_pos    = POINTER_POSITION_RST;
      pos_cnt    = '0;
      fhp_val    = '0;
      frame_ok   = 1'b0;
      pkt_open   = 1'b0;
      held       = '0;
      held_ok    = 1'b0;
      mismatches = 0;
    endfunction

    function void configure(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_ZONE_LENGTH) begin
        zone_len = value[ZONE_W-1:0];
      end else begin
        ptr_pos = value[PTRPOS_W-1:0];
      end
    endfunction

    // Appends one predicted item behind the ones already waiting.
    function void queue_item(res_t item);
      awaited_packet_items = {awaited_packet_items, item};
    endfunction

    // A new packet byte goes into the hold-back slot; the one it displaces
    // leaves as an ordinary packet byte.
    function void stash_byte(logic [BYTE_W-1:0] b);
      if (held_ok) begin
        queue_item(res_t'{packet_byte: held, packet_last: 1'b0, empty_end: 1'b0});
      end
      held    = b;
      held_ok = 1'b1;
    endfunction

    function void close_packet();
      if (held_ok) begin
        queue_item(res_t'{packet_byte: held, packet_last: 1'b1, empty_end: 1'b0});
      end else begin
        queue_item(res_t'{packet_byte: '0, packet_last: 1'b1, empty_end: 1'b1});
      end
      held_ok = 1'b0;
    endfunction

    function void frame_byte_taken(logic [BYTE_W-1:0] b, logic first);
      int pos;
      int p;
      int idx;
      pos = first ? 0 : int'(pos_cnt);
      p   = int'(ptr_pos);
      if (first) begin
        frame_ok = 1'b0;
      end
      if (pos == p) begin
        fhp_val  = {b[2:0], 8'h00};
        frame_ok = 1'b0;
      end else if (pos == p + 1) begin
        fhp_val  = {fhp_val[10:8], b};
        frame_ok = (fhp_val <= zone_len) || (fhp_val == FHP_CONT_ONLY);
        if (frame_ok && fhp_val == '0) begin
          if (pkt_open) begin
            close_packet();
          end
          pkt_open = 1'b1;
        end
      end else if (pos >= p + 2 && frame_ok) begin
        idx = pos - p - 2;
        if (idx < int'(zone_len)) begin
          if (fhp_val == FHP_CONT_ONLY || idx + 1 != int'(fhp_val)) begin
            if (pkt_open) begin
              stash_byte(b);
            end
          end else begin
            // Last byte before the pointer: it closes the open packet.
            if (pkt_open) begin
              stash_byte(b);
              close_packet();
            end
            pkt_open = 1'b1;
          end
        end
      end
      pos_cnt = (pos < int'(POS_MAX)) ? POS_W'(pos + 1) : POS_MAX;
    endfunction

    function void packet_item_seen(res_t got);
      res_t want;
      if (awaited_packet_items.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: unexpected item byte=%02h last=%0b empty=%0b",
                   got.packet_byte, got.packet_last, got.empty_end);
        end
        return;
      end
      want = awaited_packet_items.pop_front();
      if (got.packet_byte !== want.packet_byte || got.packet_last !== want.packet_last ||
          got.empty_end !== want.empty_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected byte=%02h last=%0b empty=%0b, got byte=%02h last=%0b empty=%0b",
                   want.packet_byte, want.packet_last, want.empty_end,
                   got.packet_byte, got.packet_last, got.empty_end);
        end
      end
    endfunction

    function int pending();
      return awaited_packet_items.size();
    endfunction

  endclass

endpackage

[test/mpdu_packet_extractor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdu_packet_extractor_test: self-checking bench for the packet extractor
// Streams transfer frames through the block under several register settings,
// with random gaps on both channels and one long output stall, and checks
// every packet item against a scoreboard that tracks the frame state.
// ----------------------------------------------------------------------------
module mpdu_packet_extractor_test;

  import mpe_pkg::*;
  import mpe_test_pkg::*;

  // The longest quiet spell is the deliberate output hold-off; the watchdog
  // allows several times that before it declares the block stuck.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mpe_frame_if  in_frame();
  mpe_packet_if out_packet();

  mpdu_packet_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_frame   (in_frame),
    .out_packet (out_packet),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mpdu_split_scoreboard sb = new();

  // Pacing controls shared by the sender (main sequence) and the receiver.
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  bit hold_off_req  = 1'b0;
  int zone_items_sent = 0;
  int stall_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: both channels are sampled at the rising edge, the input side
  // first so that a byte's items are predicted before any of them can be seen.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_frame.valid && in_frame.ready) begin
        sb.frame_byte_taken(in_frame.frame_byte, in_frame.frame_first);
      end
      if (out_packet.valid && out_packet.ready) begin
        sb.packet_item_seen(res_t'{packet_byte: out_packet.packet_byte,
                                   packet_last: out_packet.packet_last,
                                   empty_end:   out_packet.empty_end});
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_frame.valid && in_frame.ready) ||
        (out_packet.valid && out_packet.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: ready changes at the falling edge. A hold-off request keeps
  // ready low for the hold-off period so the output queue fills and the
  // block has to push back on its input.
  initial begin
    out_packet.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_packet.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_packet.ready <= receiver_calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // Offers one frame byte, with a random gap in front of it unless the
  // sender is calm, and returns at the falling edge after it was taken.
  task automatic send_item(logic [7:0] b, logic first);
    while (!sender_calm && $urandom_range(99) < 34) begin
      in_frame.valid <= 1'b0;
      @(negedge clk);
    end
    in_frame.valid       <= 1'b1;
    in_frame.frame_byte  <= b;
    in_frame.frame_first <= first;
    do @(posedge clk); while (!in_frame.ready);
    @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic cfg_write(logic idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.configure(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering, waits for every predicted item, then waits out the settle
  // period for bytes that cause no item.
  task automatic settle();
    in_frame.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One frame with a random pointer and random length. Most frames are full
  // length; some are cut short by the next frame mark and some run past the
  // packet zone. The pointer is biased toward its special values.
  task automatic send_random_frame();
    int          zone;
    int          ptr;
    int          full_len;
    int          frame_len;
    int          roll;
    logic [10:0] fhp;
    bit          kept;
    logic [7:0]  b;
    zone     = int'(sb.zone_len);
    ptr      = int'(sb.ptr_pos);
    full_len = ptr + 2 + zone;
    roll     = $urandom_range(99);
    if (roll < 12) begin
      fhp = '0;
    end else if (roll < 24) begin
      fhp = 11'(zone);
    end else if (roll < 38) begin
      fhp = FHP_CONT_ONLY;
    end else if (roll < 48) begin
      if (zone < 2046) begin
        fhp = 11'($urandom_range(2046, zone + 1));
      end else begin
        fhp = '0;
      end
    end else begin
      fhp = 11'($urandom_range(zone, 1));
    end
    kept = (fhp <= 11'(zone)) || (fhp == FHP_CONT_ONLY);
    roll = $urandom_range(99);
    if (roll < 75) begin
      frame_len = full_len;
    end else if (roll < 88) begin
      frame_len = $urandom_range(full_len - 1, 1);
    end else begin
      frame_len = full_len + $urandom_range(6, 1);
    end
    for (int k = 0; k < frame_len; k++) begin
      b = 8'($urandom);
      // The pointer's high byte carries random bits above its three used ones.
      if (k == ptr) begin
        b[2:0] = fhp[10:8];
      end else if (k == ptr + 1) begin
        b = fhp[7:0];
      end
      if (kept && k >= ptr + 2 && k < full_len) begin
        zone_items_sent++;
      end
      send_item(b, k == 0);
    end
  endtask

  // Loose bytes with a frame mark now and then, out of step with any frame.
  task automatic send_noise(int count);
    for (int k = 0; k < count; k++) begin
      send_item(8'($urandom), $urandom_range(7) == 0);
    end
  endtask

  // Writes both registers, then sends random frames until the requested
  // number of packet zone bytes in kept frames has gone in.
  task automatic run_phase(int zone, int ptr, int target, bit calm, bit pressure);
    int start;
    cfg_write(CFG_ZONE_LENGTH, CFG_DATA_W'(zone));
    cfg_write(CFG_POINTER_POSITION, CFG_DATA_W'(ptr));
    sender_calm   = calm;
    receiver_calm = calm;
    if (pressure) begin
      hold_off_req = 1'b1;
    end
    start = zone_items_sent;
    while (zone_items_sent - start < target) begin
      if ($urandom_range(9) == 0) begin
        send_noise($urandom_range(4, 1));
      end
      send_random_frame();
    end
    settle();
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_ZONE_LENGTH;
    cfg_data             = '0;
    in_frame.valid       = 1'b0;
    in_frame.frame_byte  = '0;
    in_frame.frame_first = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: two-byte zone with the pointer at byte 1, so a full
    // frame is five bytes. Writing the registers leaves the byte count alone,
    // so the first bytes below still start at position zero.
    cfg_write(CFG_ZONE_LENGTH, CFG_DATA_W'(2));
    cfg_write(CFG_POINTER_POSITION, CFG_DATA_W'(1));

    // Bytes before any frame mark form a frame whose pointer of zero opens
    // a packet; the zone bytes feed it.
    send_item(8'h00, 1'b0); send_item(8'hF8, 1'b0); send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0); send_item(8'h01, 1'b0);
    // Short frame with pointer zero: the held byte closes the packet as soon
    // as the pointer is read.
    send_item(8'hAA, 1'b1); send_item(8'h00, 1'b0); send_item(8'h00, 1'b0);
    // Pointer zero again with nothing held: an empty end marker.
    send_item(8'h55, 1'b1); send_item(8'h00, 1'b0); send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0); send_item(8'h7F, 1'b0);
    // Pointer equal to the zone length: the packet ends on the last zone byte.
    send_item(8'h00, 1'b1); send_item(8'hF8, 1'b0); send_item(8'h02, 1'b0);
    send_item(8'h11, 1'b0); send_item(8'h22, 1'b0);
    // Pointer past the zone: the whole frame is dropped.
    send_item(8'h3C, 1'b1); send_item(8'h00, 1'b0); send_item(8'h03, 1'b0);
    send_item(8'h33, 1'b0); send_item(8'h44, 1'b0);
    // Continuation only, then one byte past the zone that must be ignored.
    send_item(8'hC3, 1'b1); send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b0);
    send_item(8'h99, 1'b0); send_item(8'h88, 1'b0); send_item(8'h77, 1'b0);
    settle();

    // Random part with small settings. One phase runs with no gaps on either
    // side, one with a long output hold-off.
    run_phase(1, 0, 60, 1'b0, 1'b0);
    run_phase(6, 3, 100, 1'b1, 1'b0);
    run_phase(13, 2, 150, 1'b0, 1'b1);
    run_phase(40, 7, 180, 1'b0, 1'b0);

    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
